### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/llsp_pkg.sv
// ----------------------------------------------------------------------------
// llsp_pkg
// Shared types and constants of the least-loaded server picker.
// ----------------------------------------------------------------------------
`default_nettype none

package llsp_pkg;

  // Default number of server slots in the cell chain.
  localparam int unsigned SLOTS_DEF = 16;

  // Field widths.
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned PORT_W  = 16;
  localparam int unsigned STAT_W  = 2;

  // Stream word widths, padded to whole bytes.
  localparam int unsigned IN_DATA_W  = 152;
  localparam int unsigned IN_USER_W  = 8;
  localparam int unsigned OUT_DATA_W = 120;
  localparam int unsigned OUT_USER_W = 8;

  // Request kinds.
  typedef enum logic [KIND_W-1:0] {
    REQ_REGISTER = 3'd0,
    REQ_REMOVE   = 3'd1,
    REQ_UP       = 3'd2,
    REQ_DOWN     = 3'd3,
    REQ_REQUEST  = 3'd4
  } req_e;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_NONE     = 2'd1,
    ST_FULL     = 2'd2,
    ST_MISMATCH = 2'd3
  } status_e;

  // Command held stable and broadcast to every cell while a word walks the chain.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  max_conns;
    logic [CNT_W-1:0]  cur_conns;
    logic [ADDR_W-1:0] primary_addr;
    logic [ADDR_W-1:0] backup_addr;
    logic [PORT_W-1:0] server_port;
  } cmd_t;

  // Partial result handed from one cell to the next.
  typedef struct packed {
    logic              match;     // some cell owns the addressed slot
    logic              hit;       // addressed slot was occupied
    logic [CNT_W-1:0]  hit_cur;   // its count before the update
    logic              any;       // a valid slot was seen
    logic              found;     // a slot below its limit was seen
    logic [CNT_W-1:0]  best;
    logic [SLOT_W-1:0] best_slot;
    logic [ADDR_W-1:0] best_pri;
    logic [ADDR_W-1:0] best_bak;
    logic [PORT_W-1:0] best_port;
  } acc_t;

endpackage

`default_nettype wire

### hdl/llsp_cell.sv
// ----------------------------------------------------------------------------
// llsp_cell
// One server slot of the chain: holds the slot state, applies the command
// when the token passes and hands the updated partial result onward.
// ----------------------------------------------------------------------------
`default_nettype none

module llsp_cell
  import llsp_pkg::*;
#(
  parameter int unsigned CellIdx = 0
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cmd_t cmd_i,
  input  wire logic tok_i,
  input  wire acc_t acc_i,
  output logic      tok_o,
  output acc_t      acc_o
);

  logic              valid_q, valid_d;
  logic [CNT_W-1:0]  current_q;
  logic [CNT_W-1:0]  limit_q;
  logic [ADDR_W-1:0] pri_q;
  logic [ADDR_W-1:0] bak_q;
  logic [PORT_W-1:0] port_q;
  logic              tok_q;
  acc_t              acc_q, acc_d;
  logic              match;
  logic              do_load;
  logic              do_up;
  logic              do_down;

  // This cell owns the addressed slot.
  assign match = (32'(cmd_i.slot) == 32'(CellIdx));

  // Update strobes, only while the token sits on this cell.
  assign do_load = tok_i && match && (cmd_i.kind == REQ_REGISTER) && !valid_q;
  assign do_up   = tok_i && match && (cmd_i.kind == REQ_UP) && valid_q;
  assign do_down = tok_i && match && (cmd_i.kind == REQ_DOWN) && valid_q;

  // Next valid bit.
  always_comb begin
    valid_d = valid_q;
    if (do_load) begin
      valid_d = 1'b1;
    end else if (tok_i && match && (cmd_i.kind == REQ_REMOVE)) begin
      valid_d = 1'b0;
    end
  end

  // Merge this slot into the partial result.
  always_comb begin
    acc_d = acc_i;
    if (match) begin
      acc_d.match   = 1'b1;
      acc_d.hit     = valid_q;
      acc_d.hit_cur = current_q;
    end
    if ((cmd_i.kind == REQ_REQUEST) && valid_q) begin
      acc_d.any = 1'b1;
      if ((current_q < limit_q) && (!acc_i.found || (current_q < acc_i.best))) begin
        acc_d.found     = 1'b1;
        acc_d.best      = current_q;
        acc_d.best_slot = SLOT_W'(CellIdx);
        acc_d.best_pri  = pri_q;
        acc_d.best_bak  = bak_q;
        acc_d.best_port = port_q;
      end
    end
  end

  // Control state: slot valid bit and token.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_i;
    end
  end

  // Slot payload and the partial result handed to the neighbor.
  always_ff @(posedge clk_i) begin
    if (do_load) begin
      current_q <= cmd_i.cur_conns;
      limit_q   <= cmd_i.max_conns;
      pri_q     <= cmd_i.primary_addr;
      bak_q     <= cmd_i.backup_addr;
      port_q    <= cmd_i.server_port;
    end else if (do_up) begin
      current_q <= current_q + 1'b1;
    end else if (do_down) begin
      current_q <= current_q - 1'b1;
    end
    if (tok_i) begin
      acc_q <= acc_d;
    end
  end

  assign tok_o = tok_q;
  assign acc_o = acc_q;

endmodule

`default_nettype wire

### hdl/least_loaded_server_picker.sv
// ----------------------------------------------------------------------------
// least_loaded_server_picker
// Table of server slots built as a chain of cells; picks the least-loaded
// valid server and keeps the online user total.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload (low bit up)
//  s_axis    in   tuser: req_type | tdata: slot, max_conns, cur_conns,
//                 primary_addr, backup_addr, server_port
//  m_axis    out  tuser: status | tdata: chosen_slot, chosen_primary,
//                 chosen_backup, chosen_port, online_total
//
// Every word walks the whole cell chain, one cell per cycle, so the chain
// length sets how long a word takes from acceptance to a valid result, and
// the input accepts no new word while one is in flight.
// The input takes the next word as soon as a result moves into the output
// register, even while that result still waits for m_axis_tready.
// Reset clears all slots to empty and the online total to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module least_loaded_server_picker
  import llsp_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // slot[3:0], max_conns[35:4], cur_conns[67:36], primary_addr[99:68],
  // backup_addr[131:100], server_port[147:132], zero pad[151:148]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // req_type[2:0], zero pad[7:3]
  input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // chosen_slot[3:0], chosen_primary[35:4], chosen_backup[67:36],
  // chosen_port[83:68], online_total[115:84], zero pad[119:116]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // status[1:0], zero pad[7:2]
  output logic [OUT_USER_W-1:0]      m_axis_tuser
);

  logic              busy_q, busy_d;
  logic              start_q;
  cmd_t              cmd_q;
  logic              fin_vld_q, fin_vld_d;
  acc_t              fin_q;
  logic              out_vld_q, out_vld_d;
  logic [STAT_W-1:0] out_status_q, out_status_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;
  logic [ADDR_W-1:0] out_pri_q, out_pri_d;
  logic [ADDR_W-1:0] out_bak_q, out_bak_d;
  logic [PORT_W-1:0] out_port_q, out_port_d;
  logic [CNT_W-1:0]  total_q, total_d;
  logic              in_fire;
  logic              move;
  logic              tok_w [SLOTS+1];
  acc_t              acc_w [SLOTS+1];

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign move    = fin_vld_q && (!out_vld_q || m_axis_tready);

  // The chain starts in the cycle after acceptance with an empty partial result.
  assign tok_w[0] = start_q;
  assign acc_w[0] = '0;

  // Cell chain, one cell per slot.
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    llsp_cell #(
      .CellIdx (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd_q),
      .tok_i  (tok_w[g]),
      .acc_i  (acc_w[g]),
      .tok_o  (tok_w[g+1]),
      .acc_o  (acc_w[g+1])
    );
  end

  // Busy from acceptance until the result leaves the tail register.
  always_comb begin
    busy_d = busy_q;
    if (in_fire) begin
      busy_d = 1'b1;
    end else if (move) begin
      busy_d = 1'b0;
    end
  end

  // Tail register holds the finished partial result until the output is free.
  always_comb begin
    fin_vld_d = fin_vld_q;
    if (tok_w[SLOTS]) begin
      fin_vld_d = 1'b1;
    end else if (move) begin
      fin_vld_d = 1'b0;
    end
  end

  // Output valid.
  always_comb begin
    out_vld_d = out_vld_q;
    if (move) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  // Final status, chosen server and new online total.
  always_comb begin
    out_status_d = ST_OK;
    out_slot_d   = '0;
    out_pri_d    = '0;
    out_bak_d    = '0;
    out_port_d   = '0;
    total_d      = total_q;
    case (cmd_q.kind)
      REQ_REGISTER: begin
        if (!fin_q.match || fin_q.hit) begin
          out_status_d = ST_MISMATCH;
        end else begin
          total_d = total_q + cmd_q.cur_conns;
        end
      end
      REQ_REMOVE: begin
        if (!fin_q.hit) begin
          out_status_d = ST_MISMATCH;
        end else begin
          total_d = total_q - fin_q.hit_cur;
        end
      end
      REQ_UP: begin
        if (!fin_q.hit) begin
          out_status_d = ST_MISMATCH;
        end else begin
          total_d = total_q + 1'b1;
        end
      end
      REQ_DOWN: begin
        if (!fin_q.hit) begin
          out_status_d = ST_MISMATCH;
        end else begin
          total_d = total_q - 1'b1;
        end
      end
      REQ_REQUEST: begin
        if (!fin_q.any) begin
          out_status_d = ST_NONE;
        end else if (!fin_q.found) begin
          out_status_d = ST_FULL;
        end else begin
          out_slot_d = fin_q.best_slot;
          out_pri_d  = fin_q.best_pri;
          out_bak_d  = fin_q.best_bak;
          out_port_d = fin_q.best_port;
        end
      end
      default: begin
        out_status_d = ST_OK;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      start_q   <= 1'b0;
      fin_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      total_q   <= '0;
    end else begin
      busy_q    <= busy_d;
      start_q   <= in_fire;
      fin_vld_q <= fin_vld_d;
      out_vld_q <= out_vld_d;
      if (move) begin
        total_q <= total_d;
      end
    end
  end

  // Command, tail and output payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q.kind         <= s_axis_tuser[2:0];
      cmd_q.slot         <= s_axis_tdata[3:0];
      cmd_q.max_conns    <= s_axis_tdata[35:4];
      cmd_q.cur_conns    <= s_axis_tdata[67:36];
      cmd_q.primary_addr <= s_axis_tdata[99:68];
      cmd_q.backup_addr  <= s_axis_tdata[131:100];
      cmd_q.server_port  <= s_axis_tdata[147:132];
    end
    if (tok_w[SLOTS]) begin
      fin_q <= acc_w[SLOTS];
    end
    if (move) begin
      out_status_q <= out_status_d;
      out_slot_q   <= out_slot_d;
      out_pri_q    <= out_pri_d;
      out_bak_q    <= out_bak_d;
      out_port_q   <= out_port_d;
    end
  end

  assign s_axis_tready = !busy_q;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0, total_q, out_port_q, out_bak_q, out_pri_q, out_slot_q};
  assign m_axis_tuser  = {6'b0, out_status_q};

endmodule

`default_nettype wire

### hdl/llsp_checker.sv
// ----------------------------------------------------------------------------
// llsp_checker
// Port-level checks of the least-loaded server picker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module llsp_checker
  import llsp_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic [OUT_USER_W-1:0] m_axis_tuser
);

  logic in_fire;
  logic stall;
  logic not_picked;

  assign in_fire    = s_axis_tvalid && s_axis_tready;
  assign stall      = m_axis_tvalid && !m_axis_tready;
  assign not_picked = m_axis_tvalid && (m_axis_tuser[1:0] != ST_OK);

  // A result word stays offered until it is taken.
  `ASSERT_NEXT(a_out_hold, stall, m_axis_tvalid, "result word dropped while stalled")

  // A stalled result word keeps its payload.
  `ASSERT_NEXT(a_out_stable, stall, $stable(m_axis_tdata) && $stable(m_axis_tuser),
               "result word changed while stalled")

  // One word at a time: the input closes right after a word is taken.
  `ASSERT_NEXT(a_one_in_flight, in_fire, !s_axis_tready, "input open with a word in flight")

  // Failed words carry no chosen server.
  `ASSERT_IMPL(a_no_pick_zero, not_picked, m_axis_tdata[83:0] == '0,
               "chosen server fields set on a non-assigned result")

endmodule

bind least_loaded_server_picker llsp_checker u_llsp_checker (.*);

`default_nettype wire

### tb/tb_least_loaded_server_picker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_least_loaded_server_picker
// Self-checking bench for the least-loaded server picker. A short directed
// table covers empty and full tables, count wrap, tie breaking, ignored words
// and the unused request kinds. A long random run follows that mostly
// registers free slots and counts valid ones, with some noise mixed in. Both
// stream sides idle at random. Once the output side holds off for a long
// stretch so that the block fills up and stalls its input. Every result is
// compared with a hand-written value or a local copy of the server table.
// ----------------------------------------------------------------------------

module tb_least_loaded_server_picker;
  import llsp_pkg::*;

  localparam int unsigned N_SLOTS         = SLOTS_DEF;
  localparam int unsigned CLK_PERIOD      = 20;
  localparam int unsigned RANDOM_WORDS    = 1700;
  localparam int unsigned HOLD_OFF_AT     = 400;
  localparam int unsigned HOLD_OFF_CYCLES = 600;
  localparam int unsigned CYCLE_LIMIT     = 500000;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam logic [CNT_W-1:0] ONES       = '1;

  // Request kinds that the block accepts but does nothing with.
  localparam logic [KIND_W-1:0] KIND_UNUSED_A = 3'd5;
  localparam logic [KIND_W-1:0] KIND_UNUSED_B = 3'd6;
  localparam logic [KIND_W-1:0] KIND_UNUSED_C = 3'd7;

  // One input word, field by field.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  max_conns;
    logic [CNT_W-1:0]  cur_conns;
    logic [ADDR_W-1:0] primary;
    logic [ADDR_W-1:0] backup;
    logic [PORT_W-1:0] port;
  } word_t;

  // One result word, field by field.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] primary;
    logic [ADDR_W-1:0] backup;
    logic [PORT_W-1:0] port;
    logic [CNT_W-1:0]  total;
  } pick_t;

  // A directed step; typed rows carry their result written out by hand.
  typedef struct packed {
    word_t w;
    logic  typed;
    pick_t want;
  } row_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;

  // Local copy of the server table and the online total.
  logic              srv_valid [N_SLOTS];
  logic [CNT_W-1:0]  srv_cur   [N_SLOTS];
  logic [CNT_W-1:0]  srv_lim   [N_SLOTS];
  logic [ADDR_W-1:0] srv_pri   [N_SLOTS];
  logic [ADDR_W-1:0] srv_bak   [N_SLOTS];
  logic [PORT_W-1:0] srv_port  [N_SLOTS];
  logic [CNT_W-1:0]  online_sum = '0;

  pick_t       due_picks [$];
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  bit          tx_quiet    = 1'b0;
  bit          rx_quiet    = 1'b0;

  // Directed steps, starting from an empty table.
  row_t dir_rows [24] = '{
    // Request, remove and counts on an empty table.
    '{'{REQ_REQUEST, 4'd0, '0, '0, '0, '0, '0}, 1'b1,
      '{ST_NONE, 4'd0, '0, '0, '0, '0}},
    '{'{REQ_REMOVE, 4'd3, '0, '0, '0, '0, '0}, 1'b1,
      '{ST_MISMATCH, 4'd0, '0, '0, '0, '0}},
    '{'{REQ_UP, 4'd15, ONES, ONES, ONES, ONES, 16'hFFFF}, 1'b1,
      '{ST_MISMATCH, 4'd0, '0, '0, '0, '0}},
    '{'{REQ_DOWN, 4'd0, '0, '0, '0, '0, '0}, 1'b1,
      '{ST_MISMATCH, 4'd0, '0, '0, '0, '0}},
    // A slot with a zero limit is always full.
    '{'{REQ_REGISTER, 4'd0, '0, '0, ONES, '0, 16'hFFFF}, 1'b1,
      '{ST_OK, 4'd0, '0, '0, '0, '0}},
    '{'{REQ_REQUEST, 4'd0, '0, '0, '0, '0, '0}, 1'b1,
      '{ST_FULL, 4'd0, '0, '0, '0, '0}},
    // Counts at the top of the range, then wrap through zero.
    '{'{REQ_REGISTER, 4'd15, ONES, 32'hFFFF_FFFE, '0, ONES, '0}, 1'b1,
      '{ST_OK, 4'd0, '0, '0, '0, 32'hFFFF_FFFE}},
    '{'{REQ_REQUEST, 4'd0, '0, '0, '0, '0, '0}, 1'b1,
      '{ST_OK, 4'd15, '0, ONES, '0, 32'hFFFF_FFFE}},
    '{'{REQ_UP, 4'd15, '0, '0, '0, '0, '0}, 1'b1,
      '{ST_OK, 4'd0, '0, '0, '0, ONES}},
    '{'{REQ_REQUEST, 4'd0, '0, '0, '0, '0, '0}, 1'b1,
      '{ST_FULL, 4'd0, '0, '0, '0, ONES}},
    '{'{REQ_UP, 4'd15, '0, '0, '0, '0, '0}, 1'b1,
      '{ST_OK, 4'd0, '0, '0, '0, '0}},
    // Registering an occupied slot is refused.
    '{'{REQ_REGISTER, 4'd15, 32'd1, 32'd1, 32'd1, 32'd1, 16'd1}, 1'b1,
      '{ST_MISMATCH, 4'd0, '0, '0, '0, '0}},
    // Tie at count zero between slots 7 and 15, then count 7 down past zero.
    '{'{REQ_REGISTER, 4'd7, 32'd5, '0, 32'h0A00_0001, 32'hC0A8_0101, 16'd8080},
      1'b0, '0},
    '{'{REQ_REQUEST, 4'd0, '0, '0, '0, '0, '0}, 1'b0, '0},
    '{'{REQ_DOWN, 4'd7, '0, '0, '0, '0, '0}, 1'b0, '0},
    '{'{REQ_REQUEST, 4'd0, '0, '0, '0, '0, '0}, 1'b0, '0},
    '{'{REQ_REMOVE, 4'd15, '0, '0, '0, '0, '0}, 1'b0, '0},
    '{'{REQ_REMOVE, 4'd0, '0, '0, '0, '0, '0}, 1'b0, '0},
    '{'{REQ_REQUEST, 4'd0, '0, '0, '0, '0, '0}, 1'b0, '0},
    // Unused kinds change nothing.
    '{'{KIND_UNUSED_A, 4'd7, ONES, ONES, ONES, ONES, 16'hFFFF}, 1'b0, '0},
    '{'{KIND_UNUSED_B, 4'd7, '0, '0, '0, '0, '0}, 1'b0, '0},
    '{'{KIND_UNUSED_C, 4'd15, ONES, ONES, ONES, ONES, 16'hFFFF}, 1'b0, '0},
    // Removing the last server returns the total to zero.
    '{'{REQ_REMOVE, 4'd7, '0, '0, '0, '0, '0}, 1'b0, '0},
    '{'{REQ_REQUEST, 4'd0, '0, '0, '0, '0, '0}, 1'b1,
      '{ST_NONE, 4'd0, '0, '0, '0, '0}}
  };

  least_loaded_server_picker i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Applies one word to the local table and returns the result it yields.
  function automatic pick_t pick_and_count(input word_t w);
    pick_t            res;
    logic             occupied;
    logic             any;
    logic             found;
    logic [CNT_W-1:0] best;
    res      = '0;
    res.status = ST_OK;
    occupied = srv_valid[w.slot];
    case (w.kind)
      REQ_REGISTER: begin
        if (occupied) begin
          res.status = ST_MISMATCH;
        end else begin
          srv_valid[w.slot] = 1'b1;
          srv_lim[w.slot]   = w.max_conns;
          srv_cur[w.slot]   = w.cur_conns;
          srv_pri[w.slot]   = w.primary;
          srv_bak[w.slot]   = w.backup;
          srv_port[w.slot]  = w.port;
          online_sum        = online_sum + w.cur_conns;
        end
      end
      REQ_REMOVE, REQ_UP, REQ_DOWN: begin
        if (!occupied) begin
          res.status = ST_MISMATCH;
        end else if (w.kind == REQ_REMOVE) begin
          online_sum        = online_sum - srv_cur[w.slot];
          srv_valid[w.slot] = 1'b0;
        end else if (w.kind == REQ_UP) begin
          srv_cur[w.slot] = srv_cur[w.slot] + 1'b1;
          online_sum      = online_sum + 1'b1;
        end else begin
          srv_cur[w.slot] = srv_cur[w.slot] - 1'b1;
          online_sum      = online_sum - 1'b1;
        end
      end
      REQ_REQUEST: begin
        // Lowest slot with the smallest count below its limit wins.
        any   = 1'b0;
        found = 1'b0;
        best  = ONES;
        for (int i = 0; i < N_SLOTS; i++) begin
          if (srv_valid[i]) begin
            any = 1'b1;
            if (srv_cur[i] < srv_lim[i] && srv_cur[i] < best) begin
              best        = srv_cur[i];
              found       = 1'b1;
              res.slot    = SLOT_W'(i);
              res.primary = srv_pri[i];
              res.backup  = srv_bak[i];
              res.port    = srv_port[i];
            end
          end
        end
        if (!any) begin
          res.status = ST_NONE;
        end else if (!found) begin
          res.status = ST_FULL;
        end
      end
      default: begin
      end
    endcase
    res.total = online_sum;
    return res;
  endfunction

  // Offers one word after a random gap and records its result once accepted.
  task automatic send_word(input word_t w, input logic typed, input pick_t want);
    int unsigned gap;
    pick_t       pred;
    gap = tx_quiet ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= IN_USER_W'(w.kind);
    s_axis_tdata  <= IN_DATA_W'({w.port, w.backup, w.primary, w.cur_conns,
                                 w.max_conns, w.slot});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = pick_and_count(w);
    due_picks.push_back(typed ? want : pred);
  endtask

  // Clock.
  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Run limit.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Input side: reset, directed table, random words, then drain and verdict.
  initial begin : feed_words
    word_t       w;
    int          cand [$];
    int unsigned r;
    logic        aim_valid;
    bit          aim;
    for (int i = 0; i < N_SLOTS; i++) begin
      srv_valid[i] = 1'b0;
      srv_cur[i]   = '0;
      srv_lim[i]   = '0;
      srv_pri[i]   = '0;
      srv_bak[i]   = '0;
      srv_port[i]  = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 100 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
      w.kind      = REQ_REQUEST;
      w.slot      = SLOT_W'($urandom_range(0, N_SLOTS - 1));
      w.max_conns = $urandom;
      w.cur_conns = $urandom;
      w.primary   = $urandom;
      w.backup    = $urandom;
      w.port      = PORT_W'($urandom_range(0, 16'hFFFF));
      aim         = 1'b0;
      aim_valid   = 1'b0;
      r           = $urandom_range(0, 99);
      if (r < 18) begin
        // Registration, mostly into a free slot, mostly with small limits.
        w.kind    = REQ_REGISTER;
        aim       = ($urandom_range(0, 9) != 0);
        aim_valid = 1'b0;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            w.max_conns = $urandom_range(0, 4);
            w.cur_conns = $urandom_range(0, 3);
          end
          6: begin
            w.max_conns = ONES;
            w.cur_conns = ONES - $urandom_range(0, 2);
          end
          7: w.cur_conns = '0;
          default: begin
          end
        endcase
      end else if (r < 68) begin
        // Removal or counting, mostly on an occupied slot.
        if (r < 30) begin
          w.kind = REQ_REMOVE;
        end else if (r < 52) begin
          w.kind = REQ_UP;
        end else begin
          w.kind = REQ_DOWN;
        end
        aim       = ($urandom_range(0, 9) != 0);
        aim_valid = 1'b1;
      end else if (r >= 96) begin
        w.kind = KIND_W'($urandom_range(KIND_UNUSED_A, KIND_UNUSED_C));
      end
      if (aim) begin
        cand.delete();
        for (int i = 0; i < N_SLOTS; i++) begin
          if (srv_valid[i] == aim_valid) cand.push_back(i);
        end
        if (cand.size() != 0) begin
          w.slot = SLOT_W'(cand[$urandom_range(0, cand.size() - 1)]);
        end
      end
      send_word(w, 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    while (due_picks.size() != 0) @(posedge clk_i);
    repeat (N_SLOTS + 8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Output side: random stalls, one long hold-off, and the result check.
  initial begin : drain_results
    int unsigned stall;
    int unsigned picks_seen;
    pick_t       got;
    pick_t       want;
    picks_seen = 0;
    wait (rst_ni === 1'b1);
    forever begin
      if (picks_seen % 100 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      stall = rx_quiet ? 0 : $urandom_range(0, 16);
      if (picks_seen == HOLD_OFF_AT) stall = HOLD_OFF_CYCLES;
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);

      got.status = m_axis_tuser[STAT_W-1:0];
      {got.total, got.port, got.backup, got.primary, got.slot} =
        m_axis_tdata[SLOT_W+2*ADDR_W+PORT_W+CNT_W-1:0];
      if (due_picks.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("word %0d: result with nothing pending, status %0d total %h",
                   picks_seen, got.status, got.total);
        end
      end else begin
        want = due_picks.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("word %0d: expected status %0d slot %0d pri %h bak %h port %h total %h",
                     picks_seen, want.status, want.slot, want.primary, want.backup,
                     want.port, want.total);
            $display("word %0d: actual   status %0d slot %0d pri %h bak %h port %h total %h",
                     picks_seen, got.status, got.slot, got.primary, got.backup,
                     got.port, got.total);
          end
        end
      end
      picks_seen++;
    end
  end

endmodule
